// ===== rtl/core/sic_pkg.sv =====
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types, codes and constants of the stepper index calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package sic_pkg;

  // width of the step, interval and steps-per-rev counters
  localparam int unsigned COUNT_WIDTH = 16;
  // running sum of up to three intervals
  localparam int unsigned SUM_WIDTH   = COUNT_WIDTH + 2;
  // common width for compares against the 16-bit limit and output
  localparam int unsigned WIDE_WIDTH  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam int unsigned PHASE_WIDTH = 3;
  localparam int unsigned EDGE_WIDTH  = 3;
  localparam int unsigned COIL_WIDTH  = 4;
  localparam int unsigned SPR_WIDTH   = 16;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SUM_WIDTH-1:0]   sum_t;
  typedef logic [PHASE_WIDTH-1:0] phase_t;
  typedef logic [EDGE_WIDTH-1:0]  edge_cnt_t;

  // request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_CAL   = 2'd1;
  localparam logic [1:0] REQ_PLAIN = 2'd2;

  // configuration register indexes
  localparam logic CFG_MAX_STEPS = 1'b0;
  localparam logic CFG_COIL_SEQ  = 1'b1;

  // reset values
  localparam logic [15:0] MAX_STEPS_RESET = 16'd16384;
  localparam logic [31:0] COIL_SEQ_RESET  = 32'h98C4_6231;
  localparam logic [31:0] REV_RESET       = 32'd4096;

  // edge numbers within a run
  localparam edge_cnt_t EDGE_FIRST_IVAL = 3'd2;
  localparam edge_cnt_t EDGE_LAST       = 3'd4;

  // divide by three as multiply by rounded-up reciprocal
  localparam int unsigned DIV3_SHIFT = SUM_WIDTH + 2;
  localparam int unsigned PROD_WIDTH = SUM_WIDTH + DIV3_SHIFT;
  localparam logic [DIV3_SHIFT-1:0] DIV3_MULT =
    DIV3_SHIFT'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (&v) ? v : v + count_t'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stepper_index_calibrator_top.sv =====
// ----------------------------------------------------------------------------
// stepper_index_calibrator_top
// Half-step phase sequencer with index-sensor steps-per-rev calibration.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, req_type, opto, dir  | request
//  out     | out_valid/out_ready, coil, status, spr  | result
//  cfg     | cfg_we, cfg_index, cfg_data             | write only
//
//  one result beat per request beat, out_valid set in the cycle after accept
//  a new request beat is taken every cycle while the result register is
//  empty or being drained; the state update and divide-by-three multiply
//  sit between the input handshake and the result register
//  synchronous active-low reset restores the default config and state
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_index_calibrator_top
  import sic_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [31:0]           cfg_data,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_req_type,
  input  wire logic                  in_opto_level,
  input  wire logic                  in_direction,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COIL_WIDTH-1:0]      out_coil_pattern,
  output logic                       out_calib_busy,
  output logic                       out_calib_done,
  output logic                       out_calib_ok,
  output logic [SPR_WIDTH-1:0]       out_steps_per_rev
);

  logic [15:0]           max_steps_r;
  logic [31:0]           coil_seq_r;

  phase_t                phase_r,    phase_nxt;
  count_t                step_r,     step_nxt;
  edge_cnt_t             edge_r,     edge_nxt;
  logic                  first_r,    first_nxt;
  count_t                ival_r,     ival_nxt;
  sum_t                  sum_r,      sum_nxt;
  logic                  prev_opto_r, prev_opto_nxt;
  logic                  calib_r,    calib_nxt;
  count_t                rev_r,      rev_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [COIL_WIDTH-1:0] coil_out_r;
  logic                  busy_out_r, done_out_r, ok_out_r;
  logic [SPR_WIDTH-1:0]  spr_out_r;

  logic                  in_fire;
  logic                  done_nxt, ok_nxt;
  count_t                ival_inc;
  sum_t                  sum_total;
  logic [PROD_WIDTH-1:0] div_prod;
  count_t                avg;
  logic [WIDE_WIDTH-1:0] rev_wide;
  logic [SPR_WIDTH-1:0]  spr_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // interval count as it stands after this step
  assign ival_inc  = first_r ? sat_inc(ival_r) : ival_r;
  assign sum_total = sum_r + SUM_WIDTH'(ival_inc);
  assign div_prod  = PROD_WIDTH'(sum_total) * PROD_WIDTH'(DIV3_MULT);
  assign avg       = div_prod[DIV3_SHIFT +: COUNT_WIDTH];

  always_comb begin
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    edge_nxt      = edge_r;
    first_nxt     = first_r;
    ival_nxt      = ival_r;
    sum_nxt       = sum_r;
    prev_opto_nxt = prev_opto_r;
    calib_nxt     = calib_r;
    rev_nxt       = rev_r;
    done_nxt      = 1'b0;
    ok_nxt        = 1'b0;
    if (in_fire) begin
      case (in_req_type)
        REQ_START: begin
          prev_opto_nxt = in_opto_level;
          calib_nxt     = 1'b1;
          step_nxt      = '0;
          edge_nxt      = '0;
          first_nxt     = 1'b0;
          ival_nxt      = '0;
        end
        REQ_CAL: begin
          phase_nxt = phase_r + phase_t'(1);
          if (calib_r) begin
            step_nxt = sat_inc(step_r);
            ival_nxt = ival_inc;
            // falling edge of the index sensor
            if (prev_opto_r && !in_opto_level) begin
              edge_nxt = edge_r + edge_cnt_t'(1);
              if (!first_r) begin
                first_nxt = 1'b1;
              end else if (edge_nxt >= EDGE_FIRST_IVAL && edge_nxt <= EDGE_LAST) begin
                sum_nxt  = (edge_nxt == EDGE_FIRST_IVAL) ? SUM_WIDTH'(ival_inc) : sum_total;
                ival_nxt = '0;
              end
            end
            prev_opto_nxt = in_opto_level;
            if (edge_nxt >= EDGE_LAST) begin
              rev_nxt   = avg;
              calib_nxt = 1'b0;
              done_nxt  = 1'b1;
              ok_nxt    = 1'b1;
            end else if (WIDE_WIDTH'(step_nxt) > WIDE_WIDTH'(max_steps_r)) begin
              calib_nxt = 1'b0;
              done_nxt  = 1'b1;
            end
          end
        end
        REQ_PLAIN: begin
          phase_nxt = in_direction ? phase_r - phase_t'(1) : phase_r + phase_t'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // saturate to the 16-bit output
  assign rev_wide = WIDE_WIDTH'(rev_nxt);
  assign spr_nxt  = (rev_wide > WIDE_WIDTH'(16'hFFFF)) ? 16'hFFFF : rev_wide[SPR_WIDTH-1:0];

  assign out_valid_nxt = in_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= MAX_STEPS_RESET;
      coil_seq_r  <= COIL_SEQ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_STEPS: max_steps_r <= cfg_data[15:0];
        CFG_COIL_SEQ:  coil_seq_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      step_r      <= '0;
      edge_r      <= '0;
      first_r     <= 1'b0;
      ival_r      <= '0;
      sum_r       <= '0;
      prev_opto_r <= 1'b1;
      calib_r     <= 1'b0;
      rev_r       <= REV_RESET[COUNT_WIDTH-1:0];
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      edge_r      <= edge_nxt;
      first_r     <= first_nxt;
      ival_r      <= ival_nxt;
      sum_r       <= sum_nxt;
      prev_opto_r <= prev_opto_nxt;
      calib_r     <= calib_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      coil_out_r <= coil_seq_r[{phase_nxt, 2'b00} +: COIL_WIDTH];
      busy_out_r <= calib_nxt;
      done_out_r <= done_nxt;
      ok_out_r   <= ok_nxt;
      spr_out_r  <= spr_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coil_pattern  = coil_out_r;
  assign out_calib_busy    = busy_out_r;
  assign out_calib_done    = done_out_r;
  assign out_calib_ok      = ok_out_r;
  assign out_steps_per_rev = spr_out_r;

endmodule

`default_nettype wire

// ===== tb/sv/stepper_index_calibrator_top_test.sv =====
// ----------------------------------------------------------------------------
// stepper_index_calibrator_top_test
// Self-checking bench for the stepper index calibrator. A scoreboard class
// tracks phase, calibration counters and steps-per-rev, predicts the status
// beat of every accepted request and compares it field by field. Stimulus is
// a few directed requests, then bursts of random requests and calibration
// runs with random sensor waveforms mixed with noise, over several max_steps
// and coil settings, with random valid and ready gaps outside a steady phase.
// ----------------------------------------------------------------------------

module stepper_index_calibrator_top_test;
  import sic_pkg::*;

  localparam logic [1:0] REQ_NONE    = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS = 370;

  typedef struct packed {
    logic [COIL_WIDTH-1:0] coil;
    logic                  busy;
    logic                  done;
    logic                  ok;
    logic [SPR_WIDTH-1:0]  spr;
  } status_t;

  class calib_tracker;
    phase_t        phase;
    count_t        step_cnt;
    count_t        ival_cnt;
    count_t        rev;
    count_t        ivals[3];
    edge_cnt_t     edges;
    bit            first_seen;
    bit            last_opto;
    bit            running;
    logic [15:0]   limit;
    logic [31:0]   coils;
    status_t       pending[$];
    int unsigned   results;
    int unsigned   errors;

    function new();
      phase      = '0;
      step_cnt   = '0;
      ival_cnt   = '0;
      rev        = count_t'(REV_RESET);
      ivals      = '{default: '0};
      edges      = '0;
      first_seen = 1'b0;
      last_opto  = 1'b1;
      running    = 1'b0;
      limit      = MAX_STEPS_RESET;
      coils      = COIL_SEQ_RESET;
      results    = 0;
      errors     = 0;
    endfunction

    function void set_reg(input logic idx, input logic [31:0] data);
      if (idx == CFG_MAX_STEPS) begin
        limit = data[15:0];
      end else begin
        coils = data;
      end
    endfunction

    // advance the state for one accepted request and queue its status beat
    function void take_request(input logic [1:0] req, input logic opto, input logic dir);
      status_t want;
      sum_t    sum;
      want.done = 1'b0;
      want.ok   = 1'b0;
      case (req)
        REQ_START: begin
          last_opto  = opto;
          running    = 1'b1;
          step_cnt   = '0;
          edges      = '0;
          first_seen = 1'b0;
          ival_cnt   = '0;
        end
        REQ_CAL: begin
          phase = phase + phase_t'(1);
          if (running) begin
            if (step_cnt != '1) step_cnt = step_cnt + count_t'(1);
            if (first_seen && ival_cnt != '1) ival_cnt = ival_cnt + count_t'(1);
            if (last_opto && !opto) begin
              edges = edges + edge_cnt_t'(1);
              if (!first_seen) begin
                first_seen = 1'b1;
              end else if (edges >= EDGE_FIRST_IVAL && edges <= EDGE_LAST) begin
                ivals[edges - EDGE_FIRST_IVAL] = ival_cnt;
                ival_cnt = '0;
              end
            end
            last_opto = opto;
            // the last sensor edge of a run beats the step limit on the same beat
            if (edges >= EDGE_LAST) begin
              sum       = sum_t'(ivals[0]) + sum_t'(ivals[1]) + sum_t'(ivals[2]);
              rev       = count_t'(sum / 3);
              running   = 1'b0;
              want.done = 1'b1;
              want.ok   = 1'b1;
            end else if (step_cnt > limit) begin
              running   = 1'b0;
              want.done = 1'b1;
            end
          end
        end
        REQ_PLAIN: begin
          phase = dir ? phase - phase_t'(1) : phase + phase_t'(1);
        end
        default: begin
        end
      endcase
      want.coil = coils[COIL_WIDTH*phase +: COIL_WIDTH];
      want.busy = running;
      want.spr  = rev;
      pending.push_back(want);
    endfunction

    task report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(input status_t got);
      status_t want;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results));
        return;
      end
      want = pending.pop_front();
      if (got.coil !== want.coil)
        report($sformatf("result %0d coil_pattern %h, expected %h", results, got.coil, want.coil));
      if (got.busy !== want.busy)
        report($sformatf("result %0d calib_busy %b, expected %b", results, got.busy, want.busy));
      if (got.done !== want.done)
        report($sformatf("result %0d calib_done %b, expected %b", results, got.done, want.done));
      if (got.ok !== want.ok)
        report($sformatf("result %0d calib_ok %b, expected %b", results, got.ok, want.ok));
      if (got.spr !== want.spr)
        report($sformatf("result %0d steps_per_rev %0d, expected %0d", results, got.spr,
                         want.spr));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [31:0]           cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_req_type;
  logic                  in_opto_level;
  logic                  in_direction;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COIL_WIDTH-1:0] out_coil_pattern;
  logic                  out_calib_busy;
  logic                  out_calib_done;
  logic                  out_calib_ok;
  logic [SPR_WIDTH-1:0]  out_steps_per_rev;

  calib_tracker board;
  bit           steady;
  int unsigned  sent;
  int unsigned  cycles = 0;

  stepper_index_calibrator_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_opto_level     (in_opto_level),
    .in_direction      (in_direction),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_coil_pattern  (out_coil_pattern),
    .out_calib_busy    (out_calib_busy),
    .out_calib_done    (out_calib_done),
    .out_calib_ok      (out_calib_ok),
    .out_steps_per_rev (out_steps_per_rev)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls except during the steady stretch
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result('{coil: out_coil_pattern, busy: out_calib_busy,
                           done: out_calib_done, ok: out_calib_ok,
                           spr: out_steps_per_rev});
    end
  end

  task automatic send_item(input logic [1:0] req, input logic opto, input logic dir);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_opto_level <= opto;
    in_direction  <= dir;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_request(req, opto, dir);
    if (req != REQ_NONE) sent++;
  endtask

  // drop valid and let every outstanding beat come back
  task automatic drain(input int unsigned tail);
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_config(input logic idx, input logic [31:0] data);
    drain(4);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, data);
  endtask

  // one start followed by a square-wave sensor, with stray requests mixed in
  task automatic run_calibration();
    int unsigned hi_max;
    int unsigned lo_max;
    int unsigned budget;
    int unsigned left;
    int unsigned roll;
    logic        lvl;
    hi_max = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
    lo_max = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
    budget = 5 * (hi_max + lo_max) + 10;
    lvl    = 1'($urandom_range(0, 1));
    send_item(REQ_START, lvl, 1'($urandom_range(0, 1)));
    left = $urandom_range(0, lvl ? hi_max : lo_max);
    for (int n = 0; n < budget && board.running; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_item(REQ_PLAIN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (roll < 8) begin
        send_item(REQ_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (roll < 10) begin
        send_item(REQ_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (roll < 12) begin
        // sensor glitch
        send_item(REQ_CAL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        if (left == 0) begin
          lvl  = ~lvl;
          left = $urandom_range(1, lvl ? hi_max : lo_max);
        end
        left--;
        send_item(REQ_CAL, lvl, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned quota;
    int unsigned burst;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MAX_STEPS;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_req_type   = REQ_START;
    in_opto_level = 1'b0;
    in_direction  = 1'b0;
    steady        = 1'b0;
    sent          = 0;
    board         = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle behavior, wraps and interruptions
    send_item(REQ_NONE,  1'b1, 1'b1);
    send_item(REQ_PLAIN, 1'b0, 1'b0);
    send_item(REQ_PLAIN, 1'b1, 1'b1);
    send_item(REQ_PLAIN, 1'b0, 1'b1);
    send_item(REQ_CAL,   1'b0, 1'b0);
    send_item(REQ_START, 1'b1, 1'b0);
    send_item(REQ_CAL,   1'b0, 1'b0);
    send_item(REQ_PLAIN, 1'b1, 1'b1);
    send_item(REQ_NONE,  1'b0, 1'b0);
    // restart, then a short run to success with intervals 2, 3, 2
    send_item(REQ_START, 1'b1, 1'b0);
    send_item(REQ_CAL,   1'b0, 1'b0);
    send_item(REQ_CAL,   1'b1, 1'b0);
    send_item(REQ_CAL,   1'b0, 1'b0);
    send_item(REQ_CAL,   1'b1, 1'b0);
    send_item(REQ_CAL,   1'b1, 1'b0);
    send_item(REQ_CAL,   1'b0, 1'b0);
    send_item(REQ_CAL,   1'b1, 1'b0);
    send_item(REQ_CAL,   1'b0, 1'b0);
    // last sensor edge of the run on the beat that also crosses the step limit
    write_config(CFG_MAX_STEPS, 32'd6);
    send_item(REQ_START, 1'b1, 1'b0);
    for (int n = 0; n < 7; n++) send_item(REQ_CAL, n[0], 1'b0);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_config(CFG_MAX_STEPS, 32'd65534);
          write_config(CFG_COIL_SEQ, 32'hFFFF_FFFF);
        end
        1: begin
          write_config(CFG_MAX_STEPS, 32'($urandom_range(20, 150)));
          write_config(CFG_COIL_SEQ, $urandom);
        end
        2: begin
          write_config(CFG_MAX_STEPS, 32'd1);
          write_config(CFG_COIL_SEQ, 32'h0000_0000);
        end
        3: begin
          write_config(CFG_MAX_STEPS, 32'($urandom_range(1, 65534)));
          write_config(CFG_COIL_SEQ, $urandom);
        end
        default: begin
          write_config(CFG_MAX_STEPS, 32'($urandom_range(60, 400)));
          write_config(CFG_COIL_SEQ, $urandom);
        end
      endcase
      steady = (p == 1);
      quota  = sent + PHASE_ITEMS;
      while (sent < quota) begin
        if ($urandom_range(0, 3) == 0) begin
          burst = $urandom_range(1, 10);
          repeat (burst) begin
            send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
          end
        end else begin
          run_calibration();
        end
      end
    end
    steady = 1'b0;

    drain(10);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
